// ===== src/matrix4_vector_transform_core_macros.svh =====
// assertion macros for the matrix vector transform core
`ifndef MATRIX4_VECTOR_TRANSFORM_CORE_MACROS_SVH
`define MATRIX4_VECTOR_TRANSFORM_CORE_MACROS_SVH

`ifndef SYNTHESIS
`define MVT_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("mvt assertion failed");
`define MVT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("mvt assertion failed");
`else
`define MVT_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define MVT_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

// ===== src/mvt_pkg.sv =====
// shared types, constants and helpers of the matrix vector transform core
package mvt_pkg;

    localparam int FRAC_BITS = 16;
    localparam int Q_W       = 32;
    localparam int PROD_W    = 2 * Q_W;
    localparam int PAIR_W    = PROD_W + 1;
    localparam int SUM_W     = PROD_W + 2;

    localparam logic [Q_W-1:0] Q_ONE = Q_W'(1) << FRAC_BITS;

    typedef enum logic [2:0] {
        CMD_LOAD_ROW  = 3'd0,
        CMD_VEC4      = 3'd1,
        CMD_POINT     = 3'd2,
        CMD_IDENTITY  = 3'd3,
        CMD_TRANSPOSE = 3'd4
    } cmd_t;

    typedef logic [3:0][Q_W-1:0]  row_t;
    typedef logic [15:0][Q_W-1:0] mat_t;

    typedef struct packed {
        logic [2:0]            command;
        logic [1:0]            row_index;
        logic signed [Q_W-1:0] elem_0;
        logic signed [Q_W-1:0] elem_1;
        logic signed [Q_W-1:0] elem_2;
        logic signed [Q_W-1:0] elem_3;
    } in_word_t;

    typedef struct packed {
        logic                  kind;
        logic signed [Q_W-1:0] out_0;
        logic signed [Q_W-1:0] out_1;
        logic signed [Q_W-1:0] out_2;
        logic signed [Q_W-1:0] out_3;
        logic                  overflow;
    } out_word_t;

    // per-stage load strobes of the lane pipeline
    typedef struct packed {
        logic adv1;
        logic adv2;
        logic adv3;
    } lane_ctl_t;

    function automatic mat_t identity_mat();
        mat_t m;
        for (int k = 0; k < 16; k++)
        begin
            m[k] = ((k % 4) == (k / 4)) ? Q_ONE : '0;
        end
        return m;
    endfunction

endpackage

// ===== src/mvt_lane.sv =====
// one dot product lane: four products, pair sums, final sum, floor shift and saturation
module mvt_lane (
    input  logic               clk,
    input  mvt_pkg::lane_ctl_t ctl,
    input  mvt_pkg::row_t      row,
    input  mvt_pkg::row_t      vec,
    output logic [31:0]        result,
    output logic               sat
);
    import mvt_pkg::*;

    localparam logic signed [SUM_W-1:0] SAT_MAX = SUM_W'(64'sh7FFFFFFF);
    localparam logic signed [SUM_W-1:0] SAT_MIN = SUM_W'(-64'sh80000000);

    logic signed [PROD_W-1:0] prod_reg [4];
    logic signed [PROD_W-1:0] prod_next [4];
    logic signed [PAIR_W-1:0] pair_reg [2];
    logic signed [PAIR_W-1:0] pair_next [2];
    logic [Q_W-1:0]           result_reg;
    logic [Q_W-1:0]           result_next;
    logic                     sat_reg;
    logic                     sat_next;
    logic signed [SUM_W-1:0]  total;
    logic signed [SUM_W-1:0]  shifted;

    always_comb
    begin
        for (int i = 0; i < 4; i++)
        begin
            prod_next[i] = PROD_W'($signed(row[i])) * PROD_W'($signed(vec[i]));
        end
        for (int i = 0; i < 2; i++)
        begin
            pair_next[i] = PAIR_W'(prod_reg[2*i]) + PAIR_W'(prod_reg[2*i+1]);
        end
        total   = SUM_W'(pair_reg[0]) + SUM_W'(pair_reg[1]);
        shifted = total >>> FRAC_BITS;
        if (shifted > SAT_MAX)
        begin
            result_next = SAT_MAX[Q_W-1:0];
            sat_next    = 1'b1;
        end
        else if (shifted < SAT_MIN)
        begin
            result_next = SAT_MIN[Q_W-1:0];
            sat_next    = 1'b1;
        end
        else
        begin
            result_next = shifted[Q_W-1:0];
            sat_next    = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.adv1)
        begin
            prod_reg <= prod_next;
        end
        if (ctl.adv2)
        begin
            pair_reg <= pair_next;
        end
        if (ctl.adv3)
        begin
            result_reg <= result_next;
            sat_reg    <= sat_next;
        end
    end

    assign result = result_reg;
    assign sat    = sat_reg;

endmodule

// ===== src/mvt_matrix.sv =====
// matrix store: load row, identity and transpose updates
module mvt_matrix (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              accept,
    input  mvt_pkg::in_word_t word,
    output mvt_pkg::mat_t     mat
);
    import mvt_pkg::*;

    mat_t mat_reg;
    mat_t mat_next;

    always_comb
    begin
        mat_next = mat_reg;
        if (accept)
        begin
            case (word.command)
                CMD_LOAD_ROW:
                begin
                    mat_next[{word.row_index, 2'd0}] = word.elem_0;
                    mat_next[{word.row_index, 2'd1}] = word.elem_1;
                    mat_next[{word.row_index, 2'd2}] = word.elem_2;
                    mat_next[{word.row_index, 2'd3}] = word.elem_3;
                end
                CMD_IDENTITY:
                begin
                    mat_next = identity_mat();
                end
                CMD_TRANSPOSE:
                begin
                    for (int i = 0; i < 4; i++)
                    begin
                        for (int j = 0; j < 4; j++)
                        begin
                            mat_next[4*i+j] = mat_reg[4*j+i];
                        end
                    end
                end
                default:
                begin
                    mat_next = mat_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mat_reg <= identity_mat();
        end
        else
        begin
            mat_reg <= mat_next;
        end
    end

    assign mat = mat_reg;

endmodule

// ===== src/matrix4_vector_transform_core.sv =====
// top level: homogeneous 4x4 matrix times vector transform core
//
// cmd channel (cmd_valid, cmd_stall, cmd_word) takes one command word per cycle
// while cmd_stall is low: load a matrix row, transform a vec4, transform a point
// (w taken as one), reset the matrix to identity, or transpose it. every command
// gives exactly one result word on the res channel (res_valid, res_stall,
// res_word): kind 0 acknowledges a matrix update or an unused code with all other
// fields zero, kind 1 carries the transformed vector and the saturation flag.
// four lanes each form one row dot product over a three stage pipeline:
// products, pair sums, final sum with floor shift and saturation; the merge
// at the output masks unused lanes and gathers the overflow flag.
// words pass the product, pair sum and result registers to res_valid; one word
// per cycle is sustained while res_stall is low. matrix updates take effect at
// the accept edge, so a transform accepted in the next cycle sees the new matrix.
// reset (rst_n low) empties the pipeline and loads the identity matrix.
// while res_stall holds, the result word is held and the pipeline fills its
// empty stages; cmd_stall rises once every stage holds a word.
`include "matrix4_vector_transform_core_macros.svh"

module matrix4_vector_transform_core (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cmd_valid,
    output logic               cmd_stall,
    input  mvt_pkg::in_word_t  cmd_word,
    output logic               res_valid,
    input  logic               res_stall,
    output mvt_pkg::out_word_t res_word
);
    import mvt_pkg::*;

    logic      v1_reg, v1_next;
    logic      v2_reg, v2_next;
    logic      v3_reg, v3_next;
    logic      kind1_reg, kind2_reg, kind3_reg;
    logic      point1_reg, point2_reg, point3_reg;
    logic      accept;
    lane_ctl_t ctl;
    mat_t      mat;
    row_t      vec;
    logic      is_xform;
    logic      is_point;
    logic [31:0] lane_result [4];
    logic        lane_sat [4];

    assign ctl.adv3  = v2_reg && (!v3_reg || !res_stall);
    assign ctl.adv2  = v1_reg && (!v2_reg || ctl.adv3);
    assign cmd_stall = v1_reg && !ctl.adv2;
    assign accept    = cmd_valid && !cmd_stall;
    assign ctl.adv1  = accept;

    assign is_point = (cmd_word.command == CMD_POINT);
    assign is_xform = (cmd_word.command == CMD_VEC4) || is_point;

    assign vec[0] = cmd_word.elem_0;
    assign vec[1] = cmd_word.elem_1;
    assign vec[2] = cmd_word.elem_2;
    assign vec[3] = is_point ? Q_ONE : cmd_word.elem_3;

    mvt_matrix u_matrix (
        .clk    (clk),
        .rst_n  (rst_n),
        .accept (accept),
        .word   (cmd_word),
        .mat    (mat)
    );

    for (genvar r = 0; r < 4; r++)
    begin : g_lane
        mvt_lane u_lane (
            .clk    (clk),
            .ctl    (ctl),
            .row    (mat[4*r+3 -: 4]),
            .vec    (vec),
            .result (lane_result[r]),
            .sat    (lane_sat[r])
        );
    end

    always_comb
    begin
        v1_next = ctl.adv1 ? 1'b1 : (ctl.adv2 ? 1'b0 : v1_reg);
        v2_next = ctl.adv2 ? 1'b1 : (ctl.adv3 ? 1'b0 : v2_reg);
        v3_next = ctl.adv3 ? 1'b1 : ((v3_reg && !res_stall) ? 1'b0 : v3_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= v1_next;
            v2_reg <= v2_next;
            v3_reg <= v3_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.adv1)
        begin
            kind1_reg  <= is_xform;
            point1_reg <= is_point;
        end
        if (ctl.adv2)
        begin
            kind2_reg  <= kind1_reg;
            point2_reg <= point1_reg;
        end
        if (ctl.adv3)
        begin
            kind3_reg  <= kind2_reg;
            point3_reg <= point2_reg;
        end
    end

    // merge: mask unused lanes and gather saturation
    always_comb
    begin
        res_word.kind     = kind3_reg;
        res_word.out_0    = kind3_reg ? lane_result[0] : '0;
        res_word.out_1    = kind3_reg ? lane_result[1] : '0;
        res_word.out_2    = kind3_reg ? lane_result[2] : '0;
        res_word.out_3    = (kind3_reg && !point3_reg) ? lane_result[3] : '0;
        res_word.overflow = kind3_reg && (lane_sat[0] || lane_sat[1] || lane_sat[2]
                            || (lane_sat[3] && !point3_reg));
    end

    assign res_valid = v3_reg;

    `MVT_ASSERT_IMP(a_stall_needs_full, clk, rst_n, cmd_stall, v1_reg && v2_reg && v3_reg)
    `MVT_ASSERT_IMP(a_ack_zero, clk, rst_n, res_valid && !res_word.kind,
        res_word.out_0 == '0 && res_word.out_3 == '0 && !res_word.overflow)
    `MVT_ASSERT_NEXT(a_drain, clk, rst_n, v2_reg && !res_stall, res_valid)
    `MVT_ASSERT_NEXT(a_accept_fills, clk, rst_n, accept, v1_reg)

endmodule

// ===== tb/sv/matrix4_vector_transform_core_test.sv =====
// testbench of the 4x4 matrix vector transform core with a tracked shadow matrix
module matrix4_vector_transform_core_test;
    timeunit 1ns;
    timeprecision 1ps;

    import mvt_pkg::*;

    localparam int RANDOM_WORDS = 1200;
    localparam int HOLD_CYCLES  = 300;
    localparam int CYCLE_LIMIT  = 300000;
    localparam int DRAIN_CYCLES = 8;

    localparam logic [2:0] CMD_FIRST_SPARE = 3'(CMD_TRANSPOSE) + 3'd1;
    localparam logic [2:0] CMD_LAST_SPARE  = '1;

    localparam logic signed [SUM_W-1:0] SAT_HI = SUM_W'(32'sh7FFF_FFFF);
    localparam logic signed [SUM_W-1:0] SAT_LO = SUM_W'(32'sh8000_0000);

    class matrix_shadow;
        logic signed [Q_W-1:0] entries [16];
        out_word_t awaited_words [$];
        int errors;
        int n_vec;
        int n_point;
        int n_update;
        int n_spare;
        int n_sat;

        function new();
            errors   = 0;
            n_vec    = 0;
            n_point  = 0;
            n_update = 0;
            n_spare  = 0;
            n_sat    = 0;
            load_identity();
        endfunction

        function void load_identity();
            for (int k = 0; k < 16; k++)
            begin
                entries[k] = ((k % 4) == (k / 4)) ? Q_ONE : '0;
            end
        endfunction

        function out_word_t apply_command(in_word_t w);
            out_word_t r;
            logic signed [Q_W-1:0] v [4];
            logic signed [Q_W-1:0] res [4];
            logic signed [Q_W-1:0] t;
            logic signed [SUM_W-1:0] acc;
            int rows;
            r = '0;
            v[0] = w.elem_0;
            v[1] = w.elem_1;
            v[2] = w.elem_2;
            v[3] = w.elem_3;
            for (int i = 0; i < 4; i++)
            begin
                res[i] = '0;
            end
            case (w.command)
                CMD_LOAD_ROW:
                begin
                    for (int i = 0; i < 4; i++)
                    begin
                        entries[int'(w.row_index) * 4 + i] = v[i];
                    end
                    n_update++;
                end
                CMD_VEC4, CMD_POINT:
                begin
                    r.kind = 1'b1;
                    if (w.command == CMD_POINT)
                    begin
                        v[3] = Q_ONE;
                        rows = 3;
                        n_point++;
                    end
                    else
                    begin
                        rows = 4;
                        n_vec++;
                    end
                    for (int j = 0; j < rows; j++)
                    begin
                        acc = '0;
                        for (int i = 0; i < 4; i++)
                        begin
                            acc = acc + entries[j * 4 + i] * v[i];
                        end
                        acc = acc >>> FRAC_BITS;
                        if (acc > SAT_HI)
                        begin
                            res[j] = SAT_HI[Q_W-1:0];
                            r.overflow = 1'b1;
                        end
                        else if (acc < SAT_LO)
                        begin
                            res[j] = SAT_LO[Q_W-1:0];
                            r.overflow = 1'b1;
                        end
                        else
                        begin
                            res[j] = acc[Q_W-1:0];
                        end
                    end
                    if (r.overflow)
                    begin
                        n_sat++;
                    end
                end
                CMD_IDENTITY:
                begin
                    load_identity();
                    n_update++;
                end
                CMD_TRANSPOSE:
                begin
                    for (int i = 0; i < 4; i++)
                    begin
                        for (int j = i + 1; j < 4; j++)
                        begin
                            t = entries[i * 4 + j];
                            entries[i * 4 + j] = entries[j * 4 + i];
                            entries[j * 4 + i] = t;
                        end
                    end
                    n_update++;
                end
                default:
                begin
                    n_spare++;
                end
            endcase
            r.out_0 = res[0];
            r.out_1 = res[1];
            r.out_2 = res[2];
            r.out_3 = res[3];
            return r;
        endfunction

        function void note_command(in_word_t w);
            awaited_words.push_back(apply_command(w));
        endfunction

        function void compare_field(string field, logic signed [Q_W-1:0] want,
                                    logic signed [Q_W-1:0] got);
            if (want !== got)
            begin
                $error("%s: expected %0d, got %0d", field, want, got);
                errors++;
            end
        endfunction

        function void check_result(out_word_t got);
            out_word_t want;
            if (awaited_words.size() == 0)
            begin
                $error("result word arrived with none awaited");
                errors++;
                return;
            end
            want = awaited_words.pop_front();
            compare_field("kind", Q_W'(want.kind), Q_W'(got.kind));
            compare_field("out_0", want.out_0, got.out_0);
            compare_field("out_1", want.out_1, got.out_1);
            compare_field("out_2", want.out_2, got.out_2);
            compare_field("out_3", want.out_3, got.out_3);
            compare_field("overflow", Q_W'(want.overflow), Q_W'(got.overflow));
        endfunction
    endclass

    logic      clk;
    logic      rst_n;
    logic      cmd_valid;
    logic      cmd_stall;
    in_word_t  cmd_word;
    logic      res_valid;
    logic      res_stall;
    out_word_t res_word;

    bit idle_on;
    bit hold_request;
    int cycle_count;
    matrix_shadow sb;

    matrix4_vector_transform_core i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_stall (cmd_stall),
        .cmd_word  (cmd_word),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res_word  (res_word)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $error("run exceeded %0d cycles", CYCLE_LIMIT);
            $display("Mismatches found");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (cmd_valid && !cmd_stall)
            begin
                sb.note_command(cmd_word);
            end
            if (res_valid && !res_stall)
            begin
                sb.check_result(res_word);
            end
        end
    end

    // result side: random stall bursts, plus one long hold on request
    initial
    begin
        int span;
        res_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_request)
            begin
                res_stall <= 1'b1;
                repeat (HOLD_CYCLES - 1) @(negedge clk);
                hold_request = 1'b0;
            end
            else if (idle_on && $urandom_range(0, 2) == 0)
            begin
                span = $urandom_range(1, 16);
                res_stall <= 1'b1;
                repeat (span - 1) @(negedge clk);
            end
            else
            begin
                span = $urandom_range(1, 12);
                res_stall <= 1'b0;
                repeat (span - 1) @(negedge clk);
            end
        end
    end

    function automatic logic [Q_W-1:0] rand_elem();
        case ($urandom_range(0, 9))
            0: return 32'h7FFF_FFFF;
            1: return 32'h8000_0000;
            2, 3: return $urandom();
            default: return 32'($urandom_range(0, 32'h0008_0000)) - 32'h0004_0000;
        endcase
    endfunction

    task automatic send_cmd(input logic [2:0] cmd, input logic [1:0] row,
                            input logic [Q_W-1:0] e0, input logic [Q_W-1:0] e1,
                            input logic [Q_W-1:0] e2, input logic [Q_W-1:0] e3);
        in_word_t w;
        int gap;
        w.command   = cmd;
        w.row_index = row;
        w.elem_0    = e0;
        w.elem_1    = e1;
        w.elem_2    = e2;
        w.elem_3    = e3;
        if (idle_on && $urandom_range(0, 5) == 0)
        begin
            gap = $urandom_range(1, 16);
            @(negedge clk);
            cmd_valid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        cmd_valid <= 1'b1;
        cmd_word  <= w;
        do
            @(posedge clk);
        while (cmd_stall);
    endtask

    task automatic send_random();
        int pick;
        logic [2:0] cmd;
        pick = $urandom_range(0, 99);
        if (pick < 35)
            cmd = CMD_VEC4;
        else if (pick < 60)
            cmd = CMD_POINT;
        else if (pick < 85)
            cmd = CMD_LOAD_ROW;
        else if (pick < 90)
            cmd = CMD_IDENTITY;
        else if (pick < 97)
            cmd = CMD_TRANSPOSE;
        else
            cmd = 3'($urandom_range(CMD_LAST_SPARE, CMD_FIRST_SPARE));
        send_cmd(cmd, 2'($urandom_range(0, 3)), rand_elem(), rand_elem(), rand_elem(),
                 rand_elem());
    endtask

    initial
    begin
        sb           = new();
        rst_n        = 1'b0;
        cmd_valid    = 1'b0;
        cmd_word     = '0;
        idle_on      = 1'b1;
        hold_request = 1'b0;
        cycle_count  = 0;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // identity pass-through, then saturation both ways
        send_cmd(CMD_VEC4, 2'd0, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0, 32'hFFFF_FFFF);
        send_cmd(CMD_POINT, 2'd0, 32'h8000_0000, 32'h7FFF_FFFF, 32'h1, 32'h7FFF_FFFF);
        for (int r = 0; r < 4; r++)
        begin
            send_cmd(CMD_LOAD_ROW, 2'(r), 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                     32'h7FFF_FFFF);
        end
        send_cmd(CMD_VEC4, 2'd3, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
        send_cmd(CMD_VEC4, 2'd1, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
        send_cmd(CMD_POINT, 2'd2, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h0);
        send_cmd(CMD_IDENTITY, 2'd0, 32'h0, 32'h0, 32'h0, 32'h0);

        // floor rounding of negative sums and transpose
        send_cmd(CMD_LOAD_ROW, 2'd2, 32'hFFFF_FFFF, 32'h0002_0000, 32'h0000_8000,
                 32'h8000_0000);
        send_cmd(CMD_LOAD_ROW, 2'd0, 32'h0, 32'hFFFF_0000, 32'h0001_8000, 32'h0000_0003);
        send_cmd(CMD_VEC4, 2'd0, 32'h1, 32'h0001_0000, 32'h0002_0000, 32'h0);
        send_cmd(CMD_TRANSPOSE, 2'd0, 32'h0, 32'h0, 32'h0, 32'h0);
        send_cmd(CMD_VEC4, 2'd0, 32'h0001_0000, 32'hFFFF_0000, 32'h3, 32'h7FFF_FFFF);
        send_cmd(CMD_POINT, 2'd0, 32'h0001_0000, 32'hFFFF_0000, 32'h3, 32'h7FFF_FFFF);
        send_cmd(CMD_TRANSPOSE, 2'd3, 32'h0, 32'h0, 32'h0, 32'h0);
        send_cmd(CMD_VEC4, 2'd0, 32'hFFFF_FFFF, 32'h1, 32'hFFFF_8000, 32'h0001_0000);

        // unused codes leave the matrix alone
        for (int c = CMD_FIRST_SPARE; c <= CMD_LAST_SPARE; c++)
        begin
            send_cmd(3'(c), 2'(c), $urandom(), $urandom(), $urandom(), $urandom());
        end
        send_cmd(CMD_VEC4, 2'd0, 32'h0003_0000, 32'h0, 32'hFFFD_0000, 32'h0001_0000);
        send_cmd(CMD_LOAD_ROW, 2'd3, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                 32'h8000_0000);
        send_cmd(CMD_VEC4, 2'd0, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
        send_cmd(CMD_IDENTITY, 2'd1, 32'h0, 32'h0, 32'h0, 32'h0);

        for (int n = 0; n < RANDOM_WORDS; n++)
        begin
            if (n == 400)
            begin
                idle_on      = 1'b0;
                hold_request = 1'b1;
            end
            if (n == 440)
                idle_on = 1'b1;
            if (n == 900)
                idle_on = 1'b0;
            send_random();
        end
        @(negedge clk);
        cmd_valid <= 1'b0;

        while (sb.awaited_words.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("covered %0d vec4 and %0d point transforms, %0d of them saturated,",
                 sb.n_vec, sb.n_point, sb.n_sat);
        $display("%0d matrix updates and %0d unused command codes in %0d cycles",
                 sb.n_update, sb.n_spare, cycle_count);
        if (sb.errors == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end
endmodule

// ===== sim.f =====
+incdir+src
src/mvt_pkg.sv
src/mvt_lane.sv
src/mvt_matrix.sv
src/matrix4_vector_transform_core.sv
tb/sv/matrix4_vector_transform_core_test.sv
